// ----- design/assert_macros.svh -----
// Assertion macros shared by the ranker RTL.
// Needs a clk_i and an active-low rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- design/frr_pkg.sv -----
// Types and constants of the file replacement ranker.
// Used by frr_cell, file_replacement_ranker_unit and the testbench; depends on nothing.
package frr_pkg;

  localparam int unsigned IdW  = 10;  // fits the largest table
  localparam int unsigned CntW = 11;  // counts up to the largest table
  localparam int unsigned KeyW = 33;
  localparam int unsigned MaxOut = 64;

  typedef enum logic [2:0] {
    MODE_SET    = 3'd0,
    MODE_ACCESS = 3'd1,
    MODE_ROLL   = 3'd2,
    MODE_SPREAD = 3'd3,
    MODE_DELETE = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    POL_DOUBLE = 2'd0,
    POL_LRU    = 2'd1,
    POL_FIFO   = 2'd2,
    POL_LFU    = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    FS_NORMAL = 2'd0,
    FS_SPREAD = 2'd1
  } fstat_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_ACCESS,
    OP_ROLL,
    OP_LOAD,
    OP_MARK
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PASS,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  file_index;
    logic [31:0] access_time;
    logic [1:0]  file_status;
    logic [15:0] client_load;
  } in_item_t;

  typedef struct packed {
    logic [5:0]      file_id;
    logic [KeyW-1:0] rank_key;
    logic            found;
    logic            last;
  } out_item_t;

  // Broadcast command to all cells.
  typedef struct packed {
    op_e         op;
    logic        spread;
    logic [1:0]  policy;
    logic [5:0]  idx;
    logic [31:0] atime;
    logic [1:0]  status;
    logic [15:0] load;
    logic [IdW-1:0] mark_id;
  } cmd_t;

  // Selection token moving down the chain.
  typedef struct packed {
    logic            live;
    logic            hit;
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
    logic [CntW-1:0] cnt;
  } token_t;

endpackage

// ----- design/frr_cell.sv -----
// One table entry of the ranker with its stage of the selection chain.
// Depends on frr_pkg.
module frr_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  frr_pkg::cmd_t   cmd_i,
  input  frr_pkg::token_t tok_i,
  output frr_pkg::token_t tok_o
);
  import frr_pkg::*;

  localparam logic [IdW-1:0] MyId = IdW'(CellIdx);

  logic [31:0]   new_q, old_q, time_q;
  logic [1:0]    stat_q;
  logic [15:0]   load_q;
  logic          cand_q;
  logic          hit_me;
  logic [KeyW-1:0] key;
  logic          better;
  token_t        tok_d, tok_q;

  assign hit_me = ({4'b0, cmd_i.idx} == MyId);

  // Rank key under the current policy.
  always_comb begin
    case (cmd_i.policy)
      POL_DOUBLE: key = {1'b0, new_q} + {1'b0, old_q};
      POL_LRU,
      POL_FIFO:   key = {1'b0, time_q};
      default:    key = {1'b0, new_q};
    endcase
  end

  // Table entry update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_q  <= '0;
      old_q  <= '0;
      time_q <= '0;
      stat_q <= '0;
      load_q <= '0;
      cand_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_SET: begin
          if (hit_me) begin
            stat_q <= cmd_i.status;
            load_q <= cmd_i.load;
          end
        end
        OP_ACCESS: begin
          if (hit_me) begin
            if (cmd_i.policy == POL_DOUBLE || cmd_i.policy == POL_LFU) begin
              if (new_q != '1) new_q <= new_q + 32'd1;
            end else if (cmd_i.policy == POL_LRU || time_q == '0) begin
              time_q <= cmd_i.atime;
            end
          end
        end
        OP_ROLL: begin
          old_q <= new_q;
          new_q <= '0;
        end
        OP_LOAD: begin
          cand_q <= cmd_i.spread ? (stat_q == FS_NORMAL)
                                 : (load_q == '0 && stat_q != FS_SPREAD);
        end
        OP_MARK: begin
          if (cmd_i.mark_id == MyId) cand_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Spread keeps the earlier id on ties; delete takes the later one.
  always_comb begin
    better = !tok_i.hit || (cmd_i.spread ? (key > tok_i.key) : (key <= tok_i.key));
    tok_d = tok_i;
    if (tok_i.live && cand_q) begin
      tok_d.cnt = tok_i.cnt + CntW'(1);
      if (better) begin
        tok_d.hit = 1'b1;
        tok_d.id  = MyId;
        tok_d.key = key;
      end
    end
  end

  // Token stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tok_q <= '0;
    else         tok_q <= tok_d;
  end

  assign tok_o = tok_q;

endmodule

// ----- design/file_replacement_ranker_unit.sv -----
// Top level of the file replacement ranker: chain of table cells and the
// query sequencer. Depends on frr_pkg, frr_cell and assert_macros.svh.
//
// Use: items enter on in_valid_i/in_ready_o, results leave on
// out_valid_o/out_ready_i, the policy register is written on
// cfg_valid_i/cfg_ready_o (always ready; write only while idle).
// Set, access and window roll give no result.
// A query gives one result per selection pass. Each pass sends a token
// down the chain of NUM_FILES cells, one cell per cycle; for each result
// the sequencer steps from start through pass to output, and the next
// pass starts only once the previous result has been taken.
// One item is worked on at a time: in_ready_o is low from a query's
// acceptance until its last result is taken.
// A stalled receiver holds the result in the output register and the
// block waits. Reset clears the whole table and the policy at once.
module file_replacement_ranker_unit #(
  parameter int unsigned NUM_FILES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  frr_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output frr_pkg::out_item_t   out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_data_i
);
  import frr_pkg::*;
  `include "assert_macros.svh"

  state_e          state_q, state_d;
  logic [1:0]      policy_q;
  logic            spread_q;
  logic            first_q;
  logic [CntW-1:0] n_q;
  logic [6:0]      k_q;
  out_item_t       out_q;
  cmd_t            cmd;
  token_t          tok [NUM_FILES+1];
  token_t          launch;
  token_t          tail;
  logic            in_acc, pass_done, is_last;
  logic [CntW-1:0] n_eff;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign tok[0]      = launch;
  assign tail        = tok[NUM_FILES];
  assign pass_done   = (state_q == ST_PASS) && tail.live;
  assign n_eff       = first_q ? tail.cnt : n_q;
  assign is_last     = !tail.hit || ({4'b0, k_q} + CntW'(1) == n_eff)
                       || (k_q == 7'(MaxOut - 1));

  // Chain of cells.
  for (genvar g = 0; g < NUM_FILES; g++) begin : g_cell
    frr_cell #(.CellIdx(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_item_i.mode == MODE_SPREAD || in_item_i.mode == MODE_DELETE))
          state_d = ST_START;
      end
      ST_START: state_d = ST_PASS;
      ST_PASS: begin
        if (tail.live) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = out_q.last ? ST_IDLE : ST_START;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshakes, token launch and cell commands.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    launch      = '0;
    launch.live = (state_q == ST_START);
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.spread  = spread_q;
    cmd.policy  = policy_q;
    cmd.idx     = in_item_i.file_index;
    cmd.atime   = in_item_i.access_time;
    cmd.status  = in_item_i.file_status;
    cmd.load    = in_item_i.client_load;
    cmd.mark_id = tail.id;
    if (in_acc) begin
      case (in_item_i.mode)
        MODE_SET:    cmd.op = OP_SET;
        MODE_ACCESS: cmd.op = OP_ACCESS;
        MODE_ROLL:   cmd.op = (policy_q == POL_DOUBLE) ? OP_ROLL : OP_NONE;
        MODE_SPREAD: begin
          cmd.op = OP_LOAD;
          cmd.spread = 1'b1;
        end
        MODE_DELETE: begin
          cmd.op = OP_LOAD;
          cmd.spread = 1'b0;
        end
        default:     cmd.op = OP_NONE;
      endcase
    end else if (pass_done && tail.hit) begin
      cmd.op = OP_MARK;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      policy_q <= '0;
      spread_q <= 1'b0;
      first_q  <= 1'b0;
      n_q      <= '0;
      k_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) policy_q <= cfg_data_i;
      if (in_acc) begin
        spread_q <= (in_item_i.mode == MODE_SPREAD);
        first_q  <= 1'b1;
        k_q      <= '0;
      end
      if (pass_done) begin
        first_q <= 1'b0;
        if (first_q) n_q <= tail.cnt;
      end
      if (state_q == ST_OUT && out_ready_i) k_q <= k_q + 7'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (pass_done) begin
      out_q.found    <= tail.hit;
      out_q.last     <= is_last;
      out_q.file_id  <= tail.hit ? tail.id[5:0] : 6'd0;
      out_q.rank_key <= tail.hit ? tail.key : '0;
    end
  end

  assign out_item_o = out_q;

  `ASSERT_NEVER(a_one_side, in_ready_o && out_valid_o, "input and output both active")
  `ASSERT_IMPL(a_empty_last, out_valid_o && !out_item_o.found, out_item_o.last,
               "empty answer not marked last")
  `ASSERT_IMPL(a_tail_pass, tail.live, state_q == ST_PASS, "token left chain outside a pass")
  `ASSERT_IMPL(a_launch, state_q == ST_START, ##1 state_q == ST_PASS, "pass did not start")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench of file_replacement_ranker_unit: random and directed items with a
// predicting scoreboard. Depends on frr_pkg and the ranker RTL only.
module tb;
  import frr_pkg::*;

  localparam int unsigned NumFiles = 64;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = NumFiles + 20;

  // Predicts the ranker's answers and checks each result against them.
  class rank_scoreboard;
    logic [31:0] new_hits[NumFiles];
    logic [31:0] old_hits[NumFiles];
    logic [31:0] touch[NumFiles];
    logic [1:0]  fstate[NumFiles];
    logic [15:0] load[NumFiles];
    policy_e     pol;
    out_item_t   answer_q[$];
    int          errors;

    function new();
      for (int i = 0; i < NumFiles; i++) begin
        new_hits[i] = '0;
        old_hits[i] = '0;
        touch[i] = '0;
        fstate[i] = FS_NORMAL;
        load[i] = '0;
      end
      pol = POL_DOUBLE;
      errors = 0;
    endfunction

    function logic [KeyW-1:0] key_of(int i);
      case (pol)
        POL_DOUBLE: key_of = {1'b0, new_hits[i]} + {1'b0, old_hits[i]};
        POL_LRU, POL_FIFO: key_of = {1'b0, touch[i]};
        default: key_of = {1'b0, new_hits[i]};
      endcase
    endfunction

    // True if file a precedes file b in spread order.
    function bit ranks_ahead(int a, int b);
      if (key_of(a) != key_of(b)) return key_of(a) > key_of(b);
      return a < b;
    endfunction

    // Lists the files a query selects, in answer order.
    function void predict_query(bit spread);
      int ids[$];
      int pos;
      int n;
      out_item_t r;
      for (int i = 0; i < NumFiles; i++) begin
        if (spread ? (fstate[i] == FS_NORMAL)
                   : (load[i] == 0 && fstate[i] != FS_SPREAD)) begin
          pos = ids.size();
          while (pos > 0 && (spread ? ranks_ahead(i, ids[pos-1])
                                    : ranks_ahead(ids[pos-1], i)))
            pos--;
          ids.insert(pos, i);
        end
      end
      if (ids.size() == 0) begin
        r = '0;
        r.last = 1'b1;
        answer_q = {answer_q, r};
      end else begin
        n = (ids.size() > MaxOut) ? MaxOut : ids.size();
        for (int k = 0; k < n; k++) begin
          r.file_id = ids[k][5:0];
          r.rank_key = key_of(ids[k]);
          r.found = 1'b1;
          r.last = (k == n - 1);
          answer_q = {answer_q, r};
        end
      end
    endfunction

    function void note_item(in_item_t it);
      int f;
      f = it.file_index;
      case (it.mode)
        MODE_SET: begin
          fstate[f] = it.file_status;
          load[f] = it.client_load;
        end
        MODE_ACCESS: begin
          if (pol == POL_DOUBLE || pol == POL_LFU) begin
            if (new_hits[f] != 32'hFFFF_FFFF) new_hits[f]++;
          end else if (pol == POL_LRU || touch[f] == 0) begin
            touch[f] = it.access_time;
          end
        end
        MODE_ROLL: begin
          if (pol == POL_DOUBLE) begin
            for (int i = 0; i < NumFiles; i++) begin
              old_hits[i] = new_hits[i];
              new_hits[i] = '0;
            end
          end
        end
        MODE_SPREAD: predict_query(1'b1);
        MODE_DELETE: predict_query(1'b0);
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = answer_q.pop_front();
      if (got.file_id !== want.file_id || got.rank_key !== want.rank_key ||
          got.found !== want.found || got.last !== want.last) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [1:0] cfg_data_i;

  rank_scoreboard sb;
  bit in_fire, cfg_fire;
  bit stalls_on;
  int idle_cycles;
  int ready_run;

  file_replacement_ranker_unit #(.NUM_FILES(NumFiles)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Handshake monitor, scoreboard updates and the idle watchdog.
  always @(posedge clk_i) begin
    in_fire = in_valid_i && in_ready_o;
    cfg_fire = cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_fire) sb.pol = policy_e'(cfg_data_i);
      if (in_fire) sb.note_item(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if (in_fire || cfg_fire || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("tb: errors");
          $finish;
        end
      end
    end
  end

  // Receiver stalls in runs of random length.
  always @(negedge clk_i) begin
    if (ready_run == 0) begin
      out_ready_i <= !stalls_on || ($urandom_range(0, 2) != 0);
      ready_run = $urandom_range(0, 12);
    end else begin
      ready_run--;
    end
  end

  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(negedge clk_i); while (!in_fire);
  endtask

  task automatic pause_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Waits until every answer is in, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.answer_q.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_policy(policy_e p);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= p;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic [2:0] mode, int f, logic [31:0] t,
                                         logic [1:0] s, logic [15:0] l);
    in_item_t it;
    it.mode = mode;
    it.file_index = f[5:0];
    it.access_time = t;
    it.file_status = s;
    it.client_load = l;
    return it;
  endfunction

  // Random item: mostly sets and accesses on a hot subset of files.
  function automatic in_item_t random_item();
    int r;
    int f;
    logic [2:0] mode;
    r = $urandom_range(0, 99);
    if (r < 30) mode = MODE_SET;
    else if (r < 68) mode = MODE_ACCESS;
    else if (r < 76) mode = MODE_ROLL;
    else if (r < 86) mode = MODE_SPREAD;
    else if (r < 96) mode = MODE_DELETE;
    else mode = 3'($urandom_range(5, 7));
    f = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, NumFiles - 1);
    return make_item(mode, f, ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom(),
                     2'($urandom_range(0, 3)),
                     $urandom_range(0, 1) ? 16'd0 : 16'($urandom()));
  endfunction

  task automatic random_phase(int count, bit gaps);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      send_item(random_item());
      if (burst == 0) begin
        burst = $urandom_range(1, 10);
        if (gaps) pause_cycles($urandom_range(1, 8));
      end else begin
        burst--;
      end
    end
  endtask

  initial begin
    policy_e phases[5] = '{POL_LRU, POL_FIFO, POL_LFU, POL_DOUBLE, POL_LRU};
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    stalls_on = 1'b1;
    ready_run = 0;
    idle_cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: all files spreading gives empty answers to both queries.
    for (int f = 0; f < NumFiles; f++)
      send_item(make_item(MODE_SET, f, '0, FS_SPREAD, '0));
    send_item(make_item(MODE_SPREAD, 0, '0, '0, '0));
    send_item(make_item(MODE_DELETE, 0, '0, '0, '0));
    send_item(make_item(MODE_SET, 0, '0, FS_NORMAL, '0));
    send_item(make_item(MODE_SET, 63, '0, FS_NORMAL, 16'hFFFF));
    send_item(make_item(MODE_SET, 5, '0, 2'd3, '0));
    send_item(make_item(MODE_SET, 7, '0, 2'd2, 16'd1));
    send_item(make_item(MODE_ACCESS, 0, 32'hFFFF_FFFF, '0, '0));
    send_item(make_item(MODE_ACCESS, 63, '0, '0, '0));
    send_item(make_item(MODE_ACCESS, 0, '0, '0, '0));
    send_item(make_item(MODE_ROLL, 0, '0, '0, '0));
    send_item(make_item(MODE_ACCESS, 63, '0, '0, '0));
    send_item(make_item(MODE_SPREAD, 0, '0, '0, '0));
    send_item(make_item(MODE_DELETE, 0, '0, '0, '0));
    send_item(make_item(3'd5, 0, '0, '0, '0));
    send_item(make_item(3'd6, 0, '0, '0, '0));
    send_item(make_item(3'd7, 63, 32'hFFFF_FFFF, 2'd3, 16'hFFFF));
    write_policy(POL_LRU);
    send_item(make_item(MODE_ROLL, 0, '0, '0, '0));
    send_item(make_item(MODE_ACCESS, 63, 32'hFFFF_FFFF, '0, '0));
    send_item(make_item(MODE_ACCESS, 0, 32'hFFFF_FFFF, '0, '0));
    send_item(make_item(MODE_SPREAD, 0, '0, '0, '0));

    // Random part across every policy, with and without idling.
    foreach (phases[p]) begin
      write_policy(phases[p]);
      stalls_on = (p != 2);
      random_phase(25, p != 1);
    end

    drain();
    if (sb.errors == 0 && sb.answer_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
